// ===== sv/ssa_pkg.sv =====
// ssa_pkg: sizes, codes and the result record of the shifting slot array
// used by ssa_mem, ssa_core and shifting_slot_array; no dependencies
package ssa_pkg;

  localparam int DEPTH      = 64;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = IDX_W + 1;
  localparam int ITEM_W     = 32;
  localparam int IN_IDX_W   = 8;
  localparam int OP_W       = 3;
  localparam int GROW_STEPS = 4;
  localparam int GROW_W     = CNT_W + GROW_STEPS;
  localparam int IN_DATA_W  = ((IN_IDX_W + ITEM_W + 7) / 8) * 8;
  localparam int OUT_RAW_W  = ITEM_W + 1 + CNT_W + CNT_W + IDX_W + 1;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE  = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_READ   = 3'd4,
    OP_TRIM   = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_WARN  = 2'd1,
    ST_INDEX = 2'd2,
    ST_CAP   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SHUP,
    S_WR,
    S_SHDN,
    S_SCAN,
    S_RDWAIT
  } state_e;

  typedef struct packed {
    logic signed [ITEM_W-1:0] read_value;
    logic                     read_occupied;
    status_e                  status;
    logic [CNT_W-1:0]         slot_count;
    logic [CNT_W-1:0]         item_count;
    logic [IDX_W-1:0]         top_index;
    logic                     full;
  } res_t;

endpackage

// ===== sv/ssa_mem.sv =====
// ssa_mem: slot value store, one write port and one registered read port
// depends on ssa_pkg for depth and value width
module ssa_mem (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [ssa_pkg::IDX_W-1:0] waddr_i,
  input  logic [ssa_pkg::ITEM_W-1:0] wdata_i,
  input  logic [ssa_pkg::IDX_W-1:0] raddr_i,
  output logic [ssa_pkg::ITEM_W-1:0] rdata_o
);

  logic [ssa_pkg::ITEM_W-1:0] mem_q [ssa_pkg::DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/ssa_core.sv =====
// ssa_core: sequencer, occupied marks and counters of the slot array
// moves one slot per cycle through ssa_mem; depends on ssa_pkg
module ssa_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ssa_pkg::CNT_W-1:0]      cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ssa_pkg::OP_W-1:0]       in_op_i,
  input  logic [ssa_pkg::IN_IDX_W-1:0]   in_index_i,
  input  logic signed [ssa_pkg::ITEM_W-1:0] in_item_i,
  input  logic                           out_busy_i,
  output logic                           done_o,
  output ssa_pkg::res_t                  res_o
);

  localparam int IDX_W  = ssa_pkg::IDX_W;
  localparam int CNT_W  = ssa_pkg::CNT_W;
  localparam int GROW_W = ssa_pkg::GROW_W;

  ssa_pkg::state_e  state_q, state_d;
  ssa_pkg::status_e st_q, st_d;

  logic [ssa_pkg::OP_W-1:0]     op_q;
  logic [ssa_pkg::IN_IDX_W-1:0] idx_q;
  logic signed [ssa_pkg::ITEM_W-1:0] item_q;

  logic [ssa_pkg::DEPTH-1:0] marks_q, marks_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, used_q, used_d;
  logic [IDX_W-1:0] hu_q, hu_d, ptr_q, ptr_d, lim_q, lim_d;
  logic full_q, full_d;

  logic                        mem_we;
  logic [IDX_W-1:0]            mem_waddr, mem_raddr;
  logic [ssa_pkg::ITEM_W-1:0]  mem_wdata, mem_rdata;

  logic [IDX_W-1:0] idx6, ptr_inc, ptr_dec;
  logic             m;
  logic [CNT_W-1:0] hu_p1, cnt_m1, used_new, cfg_cnt;
  logic [GROW_W-1:0] idx_w, g0, g1, g2, g3;
  ssa_pkg::status_e grow_st;
  logic [CNT_W-1:0] s_plan, s_new;
  logic             need_dbl, dbl_over;
  logic             done;
  logic signed [ssa_pkg::ITEM_W-1:0] rd_val;
  logic             rd_occ;

  ssa_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign idx6    = idx_q[IDX_W-1:0];
  assign ptr_inc = ptr_q + IDX_W'(1);
  assign ptr_dec = ptr_q - IDX_W'(1);
  assign m       = marks_q[idx6];
  assign hu_p1   = {1'b0, hu_q} + CNT_W'(1);
  assign cnt_m1  = cnt_q - CNT_W'(1);
  assign used_new = used_q - CNT_W'(m);

  // growth plan: doubling on full, then up to three more while out of range
  assign idx_w = GROW_W'(idx_q);
  assign g0 = full_q ? (GROW_W'(cnt_q) << 1) : GROW_W'(cnt_q);
  assign g1 = (idx_w >= g0) ? (g0 << 1) : g0;
  assign g2 = (idx_w >= g1) ? (g1 << 1) : g1;
  assign g3 = (idx_w >= g2) ? (g2 << 1) : g2;
  assign s_plan = g3[CNT_W-1:0];

  always_comb begin
    if (idx_w >= g3) begin
      grow_st = ssa_pkg::ST_INDEX;
    end else if (g3 > GROW_W'(ssa_pkg::DEPTH)) begin
      grow_st = ssa_pkg::ST_CAP;
    end else begin
      grow_st = ssa_pkg::ST_OK;
    end
  end

  assign need_dbl = (hu_p1 >= s_plan);
  assign dbl_over = ({1'b0, s_plan} << 1) > (CNT_W + 1)'(ssa_pkg::DEPTH);
  assign s_new    = need_dbl ? (s_plan << 1) : s_plan;

  always_comb begin
    if (cfg_wdata_i == '0) begin
      cfg_cnt = CNT_W'(1);
    end else if (cfg_wdata_i > CNT_W'(ssa_pkg::DEPTH)) begin
      cfg_cnt = CNT_W'(ssa_pkg::DEPTH);
    end else begin
      cfg_cnt = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssa_pkg::S_IDLE;
      marks_q <= '0;
      cnt_q   <= CNT_W'(2);
      used_q  <= '0;
      hu_q    <= '0;
      full_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      marks_q <= marks_d;
      cnt_q   <= cnt_d;
      used_q  <= used_d;
      hu_q    <= hu_d;
      full_q  <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    lim_q <= lim_d;
    st_q  <= st_d;
    if (in_valid_i && in_ready_o) begin
      op_q   <= in_op_i;
      idx_q  <= in_index_i;
      item_q <= in_item_i;
    end
  end

  always_comb begin
    state_d   = state_q;
    st_d      = st_q;
    marks_d   = marks_q;
    cnt_d     = cnt_q;
    used_d    = used_q;
    hu_d      = hu_q;
    full_d    = full_q;
    ptr_d     = ptr_q;
    lim_d     = lim_q;
    mem_we    = 1'b0;
    mem_waddr = idx6;
    mem_wdata = item_q;
    mem_raddr = idx6;
    done      = 1'b0;
    rd_val    = '0;
    rd_occ    = 1'b0;

    case (state_q)
      ssa_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = ssa_pkg::S_EXEC;
        end
      end
      ssa_pkg::S_EXEC: begin
        if (!out_busy_i) begin
          done = 1'b1;
          case (op_q)
            ssa_pkg::OP_WRITE, ssa_pkg::OP_INSERT: begin
              if (grow_st != ssa_pkg::ST_OK) begin
                st_d = grow_st;
              end else if (op_q == ssa_pkg::OP_INSERT && m) begin
                if (need_dbl && dbl_over) begin
                  st_d = ssa_pkg::ST_CAP;
                end else begin
                  st_d      = ssa_pkg::ST_OK;
                  cnt_d     = s_new;
                  used_d    = used_q + CNT_W'(1);
                  hu_d      = hu_q + IDX_W'(1);
                  full_d    = (used_q + CNT_W'(1)) == s_new;
                  ptr_d     = hu_q;
                  mem_raddr = hu_q;
                  done      = 1'b0;
                  state_d   = ssa_pkg::S_SHUP;
                end
              end else begin
                st_d           = ssa_pkg::ST_OK;
                used_d         = used_q + CNT_W'(!m);
                hu_d           = (idx6 > hu_q) ? idx6 : hu_q;
                cnt_d          = s_plan;
                full_d         = (used_q + CNT_W'(!m)) == s_plan;
                mem_we         = 1'b1;
                marks_d[idx6]  = 1'b1;
              end
            end
            ssa_pkg::OP_DELETE: begin
              if (idx_q >= {1'b0, cnt_q}) begin
                st_d = ssa_pkg::ST_INDEX;
              end else if (cnt_q == CNT_W'(1)) begin
                st_d = ssa_pkg::ST_WARN;
                if (marks_q[0]) begin
                  marks_d[0] = 1'b0;
                  used_d     = '0;
                  full_d     = 1'b0;
                end
              end else if (!m && idx6 >= hu_q) begin
                st_d  = ssa_pkg::ST_WARN;
                cnt_d = cnt_m1;
                if (used_q == cnt_m1) begin
                  full_d = 1'b1;
                end
              end else if (hu_q == idx6) begin
                st_d          = ssa_pkg::ST_OK;
                marks_d[idx6] = 1'b0;
                cnt_d         = cnt_m1;
                used_d        = used_new;
                if (used_new != '0) begin
                  ptr_d   = idx6;
                  done    = 1'b0;
                  state_d = ssa_pkg::S_SCAN;
                end else begin
                  hu_d = '0;
                end
              end else begin
                st_d = ssa_pkg::ST_OK;
                if (!m && used_q == cnt_m1) begin
                  full_d = 1'b1;
                end
                used_d    = used_new;
                cnt_d     = cnt_m1;
                hu_d      = hu_q - IDX_W'(1);
                lim_d     = hu_q;
                ptr_d     = idx6 + IDX_W'(1);
                mem_raddr = idx6 + IDX_W'(1);
                done      = 1'b0;
                state_d   = ssa_pkg::S_SHDN;
              end
            end
            ssa_pkg::OP_CLEAR: begin
              if ({2'b00, hu_q} < idx_q) begin
                st_d = ssa_pkg::ST_WARN;
              end else if (cnt_q == CNT_W'(1)) begin
                if (!marks_q[0]) begin
                  st_d = ssa_pkg::ST_WARN;
                end else begin
                  st_d       = ssa_pkg::ST_OK;
                  marks_d[0] = 1'b0;
                  used_d     = '0;
                  full_d     = 1'b0;
                end
              end else if (!m) begin
                st_d = ssa_pkg::ST_WARN;
              end else begin
                st_d          = ssa_pkg::ST_OK;
                marks_d[idx6] = 1'b0;
                used_d        = used_q - CNT_W'(1);
                full_d        = 1'b0;
                if (hu_q == idx6) begin
                  ptr_d   = idx6;
                  done    = 1'b0;
                  state_d = ssa_pkg::S_SCAN;
                end
              end
            end
            ssa_pkg::OP_READ: begin
              if (idx_q >= {1'b0, cnt_q}) begin
                st_d = ssa_pkg::ST_INDEX;
              end else begin
                st_d    = ssa_pkg::ST_OK;
                done    = 1'b0;
                state_d = ssa_pkg::S_RDWAIT;
              end
            end
            ssa_pkg::OP_TRIM: begin
              st_d   = ssa_pkg::ST_OK;
              cnt_d  = hu_p1;
              full_d = full_q | (used_q == hu_p1);
            end
            default: begin
              st_d = ssa_pkg::ST_WARN;
            end
          endcase
          if (done) begin
            state_d = ssa_pkg::S_IDLE;
          end
        end
      end
      ssa_pkg::S_SHUP: begin
        mem_we           = 1'b1;
        mem_waddr        = ptr_inc;
        mem_wdata        = mem_rdata;
        marks_d[ptr_inc] = marks_q[ptr_q];
        mem_raddr        = ptr_dec;
        ptr_d            = ptr_dec;
        if (ptr_q == idx6) begin
          state_d = ssa_pkg::S_WR;
        end
      end
      ssa_pkg::S_WR: begin
        mem_we        = 1'b1;
        marks_d[idx6] = 1'b1;
        done          = 1'b1;
        state_d       = ssa_pkg::S_IDLE;
      end
      ssa_pkg::S_SHDN: begin
        mem_we           = 1'b1;
        mem_waddr        = ptr_dec;
        mem_wdata        = mem_rdata;
        marks_d[ptr_dec] = marks_q[ptr_q];
        mem_raddr        = ptr_inc;
        ptr_d            = ptr_inc;
        if (ptr_q == lim_q) begin
          marks_d[ptr_q] = 1'b0;
          done           = 1'b1;
          state_d        = ssa_pkg::S_IDLE;
        end
      end
      ssa_pkg::S_SCAN: begin
        if (ptr_q == '0) begin
          hu_d    = '0;
          done    = 1'b1;
          state_d = ssa_pkg::S_IDLE;
        end else if (marks_q[ptr_dec]) begin
          hu_d    = ptr_dec;
          done    = 1'b1;
          state_d = ssa_pkg::S_IDLE;
        end else begin
          ptr_d = ptr_dec;
        end
      end
      ssa_pkg::S_RDWAIT: begin
        rd_occ  = m;
        rd_val  = m ? mem_rdata : '0;
        done    = 1'b1;
        state_d = ssa_pkg::S_IDLE;
      end
      default: begin
        state_d = ssa_pkg::S_IDLE;
      end
    endcase

    // setup write reloads the slot count and empties the store
    if (cfg_we_i) begin
      marks_d = '0;
      cnt_d   = cfg_cnt;
      used_d  = '0;
      hu_d    = '0;
      full_d  = 1'b0;
    end
  end

  assign in_ready_o = (state_q == ssa_pkg::S_IDLE);
  assign done_o     = done;

  assign res_o.read_value    = rd_val;
  assign res_o.read_occupied = rd_occ;
  assign res_o.status        = st_d;
  assign res_o.slot_count    = cnt_d;
  assign res_o.item_count    = used_d;
  assign res_o.top_index     = hu_d;
  assign res_o.full          = full_d;

  a_done_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> state_q != ssa_pkg::S_IDLE)
    else $error("result produced while idle");

  a_shup_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ssa_pkg::S_SHUP |-> ptr_q >= idx6)
    else $error("upward move ran below the target slot");

  a_shdn_top : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ssa_pkg::S_SHDN && ptr_q == lim_q) |=> !marks_q[$past(lim_q)])
    else $error("old top slot still marked after downward move");

endmodule

// ===== sv/shifting_slot_array.sv =====
// shifting_slot_array: top level, stream ports, setup port and result register
// depends on ssa_pkg and ssa_core (which holds ssa_mem)
//
//   channel   direction  transfer when           payload
//   s_axis    in         tvalid & tready         tuser op, tdata index and item
//   m_axis    out        tvalid & tready         tuser status, tdata read and counts
//   cfg       in         cfg_we_i                cfg_wdata_i initial slot count
//
// overwrite, clear, trim, delete without moves, errors: done in the execute state;
// read waits for the registered read; insert on a used slot moves slots top..index
// up, one per cycle, then writes the item; delete with moves shifts slots down;
// deleting or clearing the top slot adds a downward search, one mark per cycle
// reset empties the store at once and loads a slot count of 2; a new item is
// taken while a result waits, and work stalls only when its result can't be held
module shifting_slot_array (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ssa_pkg::CNT_W-1:0]         cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // index, item
  input  logic [ssa_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // op
  input  logic [ssa_pkg::OP_W-1:0]          s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // read_value, read_occupied, slot_count, item_count, top_index, full_res
  output logic [ssa_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // status
  output logic [1:0]                        m_axis_tuser
);

  logic          out_valid_q;
  ssa_pkg::res_t out_res_q;
  ssa_pkg::res_t core_res;
  logic          core_done;
  logic          out_busy;

  assign out_busy = out_valid_q && !m_axis_tready;

  ssa_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .in_index_i  (s_axis_tdata[ssa_pkg::IN_IDX_W-1:0]),
    .in_item_i   (s_axis_tdata[ssa_pkg::IN_IDX_W +: ssa_pkg::ITEM_W]),
    .out_busy_i  (out_busy),
    .done_o      (core_done),
    .res_o       (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (core_done) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_done) begin
      out_res_q <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.status;
  assign m_axis_tdata  = {(ssa_pkg::OUT_DATA_W - ssa_pkg::OUT_RAW_W)'(0),
                          out_res_q.full, out_res_q.top_index, out_res_q.item_count,
                          out_res_q.slot_count, out_res_q.read_occupied,
                          out_res_q.read_value};

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_done |-> !out_busy)
    else $error("result register overwritten before transfer");

endmodule

// ===== test/shifting_slot_array_tb.sv =====
// shifting_slot_array_tb: self-checking bench for the shifting slot array, driving
// random and directed operations through the stream ports and checking every result
// depends on ssa_pkg and shifting_slot_array
module shifting_slot_array_tb;
  import ssa_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;
  localparam int OCC_B = ITEM_W;
  localparam int SC_B  = OCC_B + 1;
  localparam int IC_B  = SC_B + CNT_W;
  localparam int TI_B  = IC_B + CNT_W;
  localparam int FU_B  = TI_B + IDX_W;
  localparam int HOLD_CYCLES = 300;
  localparam int BACKLOG_MAX = 4;

  typedef struct {
    logic [OP_W-1:0]     op;
    logic [IN_IDX_W-1:0] index;
    logic [ITEM_W-1:0]   item;
  } array_op_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CNT_W-1:0]      cfg_wdata_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [OP_W-1:0]       s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0]            m_axis_tuser;

  // shadow of the array state
  logic [ITEM_W-1:0] slot_val [DEPTH];
  bit                slot_mark [DEPTH];
  int                slots;
  int                used;
  int                top;
  bit                full_f;

  array_op_t backlog[$];
  res_t      due_results[$];
  array_op_t cur_op;
  int        errors = 0;
  int        tx_idle_pct = 0;
  int        rx_idle_pct = 0;
  int        rx_hold_left = 0;
  bit        hold_req = 1'b0;

  shifting_slot_array u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic void reload_store(logic [CNT_W-1:0] v);
    int n;
    n = v;
    if (n == 0) n = 1;
    if (n > DEPTH) n = DEPTH;
    for (int i = 0; i < DEPTH; i++) begin
      slot_val[i] = '0;
      slot_mark[i] = 1'b0;
    end
    slots = n;
    used = 0;
    top = 0;
    full_f = 1'b0;
  endfunction

  function automatic void wipe_slot(int i);
    slot_val[i] = '0;
    slot_mark[i] = 1'b0;
  endfunction

  function automatic void lower_top(int from);
    for (int i = from; i > 0; i--) begin
      if (slot_mark[i-1]) begin
        top = i - 1;
        return;
      end
    end
    top = 0;
  endfunction

  function automatic status_e grow_plan(int idx, inout int cnt, inout bit fl);
    int n;
    bit f;
    n = cnt;
    f = fl;
    if (f) begin
      n = n * 2;
      f = 1'b0;
    end
    for (int k = 0; k < 3 && idx + 1 > n; k++) n = n * 2;
    if (idx + 1 > n) return ST_INDEX;
    if (n > DEPTH) return ST_CAP;
    cnt = n;
    fl = f;
    return ST_OK;
  endfunction

  function automatic status_e apply_write(int idx, logic [ITEM_W-1:0] v, bit shift);
    int s;
    bit f;
    status_e st;
    s = slots;
    f = full_f;
    st = grow_plan(idx, s, f);
    if (st != ST_OK) return st;
    if (shift && slot_mark[idx]) begin
      if (top + 1 >= s) begin
        if (s * 2 > DEPTH) return ST_CAP;
        s = s * 2;
        f = 1'b0;
      end
      for (int i = top + 1; i > idx; i--) begin
        slot_val[i] = slot_val[i-1];
        slot_mark[i] = slot_mark[i-1];
      end
      top++;
      used++;
    end else begin
      if (!slot_mark[idx]) used++;
      if (top < idx) top = idx;
    end
    slots = s;
    full_f = f;
    slot_val[idx] = v;
    slot_mark[idx] = 1'b1;
    if (used == slots) full_f = 1'b1;
    return ST_OK;
  endfunction

  function automatic status_e apply_delete(int idx);
    if (idx + 1 > slots) return ST_INDEX;
    if (slots == 1) begin
      if (slot_mark[0]) begin
        wipe_slot(0);
        used = 0;
        full_f = 1'b0;
      end
      return ST_WARN;
    end
    if (!slot_mark[idx] && idx >= top) begin
      slots--;
      if (used == slots) full_f = 1'b1;
      return ST_WARN;
    end
    if (slot_mark[idx]) used--;
    if (top == idx) begin
      wipe_slot(idx);
      slots--;
      if (used >= 1) lower_top(idx);
      else top = 0;
    end else begin
      if (!slot_mark[idx] && used == slots - 1) full_f = 1'b1;
      for (int i = idx; i < top; i++) begin
        slot_val[i] = slot_val[i+1];
        slot_mark[i] = slot_mark[i+1];
      end
      wipe_slot(top);
      top--;
      slots--;
    end
    return ST_OK;
  endfunction

  function automatic status_e apply_clear(int idx);
    if (top < idx) return ST_WARN;
    if (slots == 1) begin
      if (!slot_mark[0]) return ST_WARN;
      wipe_slot(0);
      used = 0;
      full_f = 1'b0;
      return ST_OK;
    end
    if (!slot_mark[idx]) return ST_WARN;
    if (top == idx) lower_top(idx);
    wipe_slot(idx);
    used--;
    full_f = 1'b0;
    return ST_OK;
  endfunction

  function automatic res_t apply_op(array_op_t a);
    res_t r;
    int idx;
    status_e st;
    idx = a.index;
    r.read_value = '0;
    r.read_occupied = 1'b0;
    case (a.op)
      OP_WRITE:  st = apply_write(idx, a.item, 1'b0);
      OP_INSERT: st = apply_write(idx, a.item, 1'b1);
      OP_DELETE: st = apply_delete(idx);
      OP_CLEAR:  st = apply_clear(idx);
      OP_READ: begin
        if (idx >= slots || idx >= DEPTH) begin
          st = ST_INDEX;
        end else begin
          r.read_occupied = slot_mark[idx];
          r.read_value = slot_mark[idx] ? slot_val[idx] : '0;
          st = ST_OK;
        end
      end
      OP_TRIM: begin
        slots = top + 1;
        if (used == slots) full_f = 1'b1;
        st = ST_OK;
      end
      default: st = ST_WARN;
    endcase
    r.status = st;
    r.slot_count = CNT_W'(slots);
    r.item_count = CNT_W'(used);
    r.top_index = IDX_W'(top);
    r.full = full_f;
    return r;
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) due_results.push_back(apply_op(cur_op));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (backlog.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          cur_op = backlog.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {cur_op.item, cur_op.index};
          s_axis_tuser <= cur_op.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_hold_left <= 0;
    end else if (hold_req) begin
      rx_hold_left <= HOLD_CYCLES;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end
  end

  function automatic void check_result();
    res_t exp_r;
    res_t got_r;
    got_r.read_value = m_axis_tdata[ITEM_W-1:0];
    got_r.read_occupied = m_axis_tdata[OCC_B];
    got_r.slot_count = m_axis_tdata[SC_B +: CNT_W];
    got_r.item_count = m_axis_tdata[IC_B +: CNT_W];
    got_r.top_index = m_axis_tdata[TI_B +: IDX_W];
    got_r.full = m_axis_tdata[FU_B];
    got_r.status = status_e'(m_axis_tuser);
    if (due_results.size() == 0) begin
      $error("result transfer with nothing expected");
      errors++;
      return;
    end
    exp_r = due_results.pop_front();
    if (got_r.read_value !== exp_r.read_value) begin
      $error("read_value: expected %0d, got %0d", exp_r.read_value, got_r.read_value);
      errors++;
    end
    if (got_r.read_occupied !== exp_r.read_occupied) begin
      $error("read_occupied: expected %0d, got %0d", exp_r.read_occupied,
             got_r.read_occupied);
      errors++;
    end
    if (got_r.status !== exp_r.status) begin
      $error("status: expected %0d, got %0d", exp_r.status, got_r.status);
      errors++;
    end
    if (got_r.slot_count !== exp_r.slot_count) begin
      $error("slot_count: expected %0d, got %0d", exp_r.slot_count, got_r.slot_count);
      errors++;
    end
    if (got_r.item_count !== exp_r.item_count) begin
      $error("item_count: expected %0d, got %0d", exp_r.item_count, got_r.item_count);
      errors++;
    end
    if (got_r.top_index !== exp_r.top_index) begin
      $error("top_index: expected %0d, got %0d", exp_r.top_index, got_r.top_index);
      errors++;
    end
    if (got_r.full !== exp_r.full) begin
      $error("full_res: expected %0d, got %0d", exp_r.full, got_r.full);
      errors++;
    end
  endfunction

  // receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      m_axis_tready <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic push_op(logic [OP_W-1:0] op, logic [IN_IDX_W-1:0] index,
                         logic [ITEM_W-1:0] item);
    array_op_t a;
    a.op = op;
    a.index = index;
    a.item = item;
    while (backlog.size() >= BACKLOG_MAX) @(negedge clk_i);
    backlog.push_back(a);
  endtask

  // sender pause until every result is back
  task automatic settle();
    while (backlog.size() != 0 || s_axis_tvalid || due_results.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic load_setup(logic [CNT_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    reload_store(v);
    @(negedge clk_i);
  endtask

  task automatic run_random(int n, int w_wr, int w_ins, int w_del, int w_clr,
                            int w_rd, int w_trim, int w_bad);
    int wts[7];
    int total;
    int pick;
    int sel;
    int r;
    int hi;
    logic [OP_W-1:0]     op;
    logic [IN_IDX_W-1:0] index;
    logic [ITEM_W-1:0]   item;
    wts = '{w_wr, w_ins, w_del, w_clr, w_rd, w_trim, w_bad};
    total = 0;
    foreach (wts[k]) total += wts[k];
    repeat (n) begin
      pick = $urandom_range(total - 1);
      sel = 0;
      while (pick >= wts[sel]) begin
        pick -= wts[sel];
        sel++;
      end
      case (sel)
        0: op = OP_WRITE;
        1: op = OP_INSERT;
        2: op = OP_DELETE;
        3: op = OP_CLEAR;
        4: op = OP_READ;
        5: op = OP_TRIM;
        default: op = $urandom_range(1) ? OP_UNUSED_HI : OP_UNUSED_LO;
      endcase
      r = $urandom_range(99);
      if (r < 70) begin
        hi = (slots > 0) ? slots - 1 : 0;
      end else if (r < 80) begin
        hi = (top + 1 < DEPTH) ? top + 1 : DEPTH - 1;
      end else if (r < 90) begin
        hi = slots * 2 + 4;
        if (hi > 255) hi = 255;
      end else begin
        hi = 255;
      end
      index = IN_IDX_W'($urandom_range(hi));
      r = $urandom_range(99);
      case (r)
        0, 1:    item = 32'h8000_0000;
        2, 3:    item = 32'h7fff_ffff;
        4, 5:    item = 32'hffff_ffff;
        6:       item = '0;
        default: item = $urandom;
      endcase
      push_op(op, index, item);
    end
  endtask

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    reload_store(CNT_W'(2));
    tx_idle_pct = 24;
    rx_idle_pct = 76;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset setting: growth, shifts, errors
    push_op(OP_READ,   8'd0,   32'h0);
    push_op(OP_READ,   8'd255, 32'h0);
    push_op(OP_WRITE,  8'd0,   32'h7fff_ffff);
    push_op(OP_WRITE,  8'd1,   32'h8000_0000);
    push_op(OP_WRITE,  8'd2,   32'hffff_ffff);
    push_op(OP_INSERT, 8'd0,   32'h0);
    push_op(OP_INSERT, 8'd1,   32'h5a5a_a5a5);
    push_op(OP_WRITE,  8'd255, 32'h1234_5678);
    push_op(OP_WRITE,  8'd40,  32'hdead_beef);
    push_op(OP_WRITE,  8'd255, 32'h1);
    push_op(OP_READ,   8'd1,   32'h0);
    push_op(OP_CLEAR,  8'd40,  32'h0);
    push_op(OP_CLEAR,  8'd40,  32'h0);
    push_op(OP_DELETE, 8'd2,   32'h0);
    push_op(OP_DELETE, 8'd3,   32'h0);
    push_op(OP_DELETE, 8'd10,  32'h0);
    push_op(OP_DELETE, 8'd200, 32'h0);
    push_op(OP_TRIM,   8'd0,   32'h0);
    push_op(OP_UNUSED_LO, 8'd0, 32'hffff_ffff);
    push_op(OP_UNUSED_HI, 8'd255, 32'h0);
    settle();

    // single slot cases
    load_setup(CNT_W'(1));
    push_op(OP_DELETE, 8'd0, 32'h0);
    push_op(OP_WRITE,  8'd0, 32'h0f0f_0f0f);
    push_op(OP_CLEAR,  8'd0, 32'h0);
    push_op(OP_CLEAR,  8'd0, 32'h0);
    push_op(OP_WRITE,  8'd0, 32'h8000_0001);
    push_op(OP_DELETE, 8'd0, 32'h0);
    run_random(200, 25, 20, 15, 12, 18, 5, 5);
    settle();

    load_setup(CNT_W'(64));
    run_random(200, 25, 20, 15, 12, 18, 5, 5);
    settle();

    tx_idle_pct = 76;
    rx_idle_pct = 24;
    load_setup(CNT_W'(127));
    run_random(150, 40, 30, 5, 5, 15, 3, 2);
    settle();

    load_setup(CNT_W'(0));
    run_random(150, 25, 20, 15, 12, 18, 5, 5);
    settle();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    load_setup(CNT_W'(5));
    hold_req = 1'b1;
    @(negedge clk_i);
    hold_req = 1'b0;
    run_random(200, 30, 25, 10, 10, 15, 5, 5);
    settle();

    load_setup(CNT_W'(17));
    run_random(150, 15, 10, 35, 20, 15, 3, 2);
    settle();

    load_setup(CNT_W'(2));
    run_random(100, 25, 20, 15, 12, 18, 5, 5);
    settle();

    repeat (150) @(posedge clk_i);
    if (errors == 0 && due_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
